// File: design/dpb_pkg.sv
// Shared types and constants for the delta plan builder.
package dpb_pkg;

    localparam int OUT_OFFSET_W   = 48;
    localparam int OFFSET_WIDTH_DEF = 48;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [1:0] ACT_DROP   = 2'd0;
    localparam logic [1:0] ACT_KEEP   = 2'd1;
    localparam logic [1:0] ACT_INSERT = 2'd2;

    localparam logic ORIGIN_SRC = 1'b0;
    localparam logic ORIGIN_DST = 1'b1;

    // One plan interval as it leaves the block.
    typedef struct packed {
        logic                    origin;
        logic [OUT_OFFSET_W-1:0] start_off;
        logic [OUT_OFFSET_W-1:0] end_off;
        logic                    fin;
        logic                    wrapped;
    } t_interval;

    // Everything one diff entry emits: one or two intervals, slot a first.
    typedef struct packed {
        logic      two;
        t_interval a;
        t_interval b;
    } t_plan_rec;

endpackage

// File: design/dpb_front.sv
// Front end: tracks offsets, merges intervals and forms at most one record per entry.
module dpb_front #(
    parameter int OFFSET_WIDTH = dpb_pkg::OFFSET_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_q_full,
    input  logic [1:0]        i_action,
    input  logic [31:0]       i_entry_size,
    input  logic              i_end_of_script,
    output logic              o_rec_push,
    output dpb_pkg::t_plan_rec o_rec
);
    import dpb_pkg::*;

    localparam int SUM_W = ((OFFSET_WIDTH > 32) ? OFFSET_WIDTH : 32) + 1;

    function automatic logic [OUT_OFFSET_W-1:0] to_out(input logic [OFFSET_WIDTH-1:0] x);
        logic [OUT_OFFSET_W+OFFSET_WIDTH-1:0] t;
        t = {{OUT_OFFSET_W{1'b0}}, x};
        return t[OUT_OFFSET_W-1:0];
    endfunction

    logic [OFFSET_WIDTH-1:0] r_src, n_src;
    logic [OFFSET_WIDTH-1:0] r_dst, n_dst;
    logic                    r_held_valid, n_held_valid;
    logic                    r_held_origin, n_held_origin;
    logic [OFFSET_WIDTH-1:0] r_held_start, n_held_start;
    logic [OFFSET_WIDTH-1:0] r_held_end, n_held_end;
    logic                    r_ovf, n_ovf;

    logic [SUM_W-1:0]        src_sum, dst_sum;
    logic                    src_wrap, dst_wrap;
    logic                    have_new, new_origin;
    logic [OFFSET_WIDTH-1:0] new_start, new_end;
    logic                    merge, emit_held, emit_last, accept;
    logic                    ovf_step;
    logic                    h_valid, h_origin;
    logic [OFFSET_WIDTH-1:0] h_start, h_end;
    t_interval               old_iv, last_iv;

    assign accept   = i_valid & ~i_q_full;
    assign src_sum  = SUM_W'(r_src) + SUM_W'(i_entry_size);
    assign dst_sum  = SUM_W'(r_dst) + SUM_W'(i_entry_size);
    assign src_wrap = |src_sum[SUM_W-1:OFFSET_WIDTH];
    assign dst_wrap = |dst_sum[SUM_W-1:OFFSET_WIDTH];

    always_comb begin
        n_src      = r_src;
        n_dst      = r_dst;
        ovf_step   = r_ovf;
        have_new   = 1'b0;
        new_origin = ORIGIN_SRC;
        new_start  = r_src;
        new_end    = r_src;
        unique case (i_action)
            ACT_DROP: begin
                n_src    = src_sum[OFFSET_WIDTH-1:0];
                ovf_step = r_ovf | src_wrap;
            end
            ACT_KEEP: begin
                n_src      = src_sum[OFFSET_WIDTH-1:0];
                n_dst      = dst_sum[OFFSET_WIDTH-1:0];
                ovf_step   = r_ovf | src_wrap | dst_wrap;
                have_new   = 1'b1;
                new_origin = ORIGIN_SRC;
                new_start  = r_src;
                new_end    = src_sum[OFFSET_WIDTH-1:0];
            end
            ACT_INSERT: begin
                n_dst      = dst_sum[OFFSET_WIDTH-1:0];
                ovf_step   = r_ovf | dst_wrap;
                have_new   = 1'b1;
                new_origin = ORIGIN_DST;
                new_start  = r_dst;
                new_end    = dst_sum[OFFSET_WIDTH-1:0];
            end
            default: begin
            end
        endcase
        // The script ends: restart both offsets.
        if (i_end_of_script) begin
            n_src = '0;
            n_dst = '0;
        end
    end

    assign merge     = have_new & r_held_valid & (r_held_origin == new_origin)
                     & (r_held_end == new_start);
    assign emit_held = have_new & r_held_valid & ~merge;

    // Held interval after this entry, before any end-of-script clear.
    always_comb begin
        h_valid  = r_held_valid;
        h_origin = r_held_origin;
        h_start  = r_held_start;
        h_end    = r_held_end;
        if (merge) begin
            h_end = new_end;
        end else if (have_new) begin
            h_valid  = 1'b1;
            h_origin = new_origin;
            h_start  = new_start;
            h_end    = new_end;
        end
    end

    assign emit_last = i_end_of_script & h_valid;

    always_comb begin
        old_iv.origin    = r_held_origin;
        old_iv.start_off = to_out(r_held_start);
        old_iv.end_off   = to_out(r_held_end);
        old_iv.fin       = 1'b0;
        old_iv.wrapped   = ovf_step;
        last_iv.origin    = h_origin;
        last_iv.start_off = to_out(h_start);
        last_iv.end_off   = to_out(h_end);
        last_iv.fin       = 1'b1;
        last_iv.wrapped   = ovf_step;
        o_rec.two = emit_held & emit_last;
        o_rec.a   = emit_held ? old_iv : last_iv;
        o_rec.b   = last_iv;
    end

    assign o_rec_push = accept & (emit_held | emit_last);

    always_comb begin
        n_held_valid  = h_valid;
        n_held_origin = h_origin;
        n_held_start  = h_start;
        n_held_end    = h_end;
        n_ovf         = ovf_step;
        if (i_end_of_script) begin
            n_held_valid = 1'b0;
            n_ovf        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src        <= '0;
            r_dst        <= '0;
            r_held_valid <= 1'b0;
            r_ovf        <= 1'b0;
        end else if (accept) begin
            r_src        <= n_src;
            r_dst        <= n_dst;
            r_held_valid <= n_held_valid;
            r_ovf        <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held_origin <= n_held_origin;
            r_held_start  <= n_held_start;
            r_held_end    <= n_held_end;
        end
    end

endmodule

// File: design/dpb_queue.sv
// Short record queue between the front end and the back end.
module dpb_queue #(
    parameter int QUEUE_DEPTH = dpb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dpb_pkg::t_plan_rec i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_nonempty,
    output dpb_pkg::t_plan_rec o_head
);
    import dpb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    t_plan_rec        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push & ~o_full;
    assign do_pop     = i_pop & o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/dpb_back.sv
// Back end: splits records into single intervals and holds the output register.
module dpb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_nonempty,
    input  dpb_pkg::t_plan_rec i_q_head,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output dpb_pkg::t_interval o_iv
);
    import dpb_pkg::*;

    logic      r_out_valid, n_out_valid;
    logic      r_sub, n_sub;
    t_interval r_out;
    logic      load;

    // Refill when the output slot is free or its interval leaves this cycle.
    assign load    = i_q_nonempty & (~r_out_valid | i_pop);
    assign o_q_pop = load & (r_sub | ~i_q_head.two);

    always_comb begin
        n_out_valid = r_out_valid;
        n_sub       = r_sub;
        if (load) begin
            n_out_valid = 1'b1;
            n_sub       = i_q_head.two & ~r_sub;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sub       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sub       <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_sub ? i_q_head.b : i_q_head.a;
        end
    end

    assign o_empty = ~r_out_valid;
    assign o_iv    = r_out;

endmodule

// File: design/delta_plan_builder_top.sv
// Top level of the delta plan builder: diff entries in, copy/insert intervals out.
//
//  channel   direction  handshake          payload
//  -------   ---------  -----------------  ------------------------------------------
//  entries   in         push / full        i_action, i_entry_size, i_end_of_script
//  plan      out        empty / pop        o_origin_sel, o_start_offset, o_end_offset,
//                                          o_final_interval, o_wrapped
//
//  One diff entry is taken per cycle while full is low; the front end's offset add
//  and merge compare finish in that cycle and write at most one record to the queue.
//  One interval leaves per cycle from the output register while pop is high, so an
//  entry that emits two intervals takes two pops; the queue absorbs such bursts.
//  The first interval an entry causes passes through the queue, then the output register.
//  Synchronous active-low reset clears offsets, held interval, flag and queue.
//  full rises only while the queue is full; a stalled plan side fills it and then
//  holds off new entries.
module delta_plan_builder_top #(
    parameter int OFFSET_WIDTH = dpb_pkg::OFFSET_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = dpb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_entry_size,
    input  logic        i_end_of_script,
    output logic        empty,
    input  logic        pop,
    output logic        o_origin_sel,
    output logic [dpb_pkg::OUT_OFFSET_W-1:0] o_start_offset,
    output logic [dpb_pkg::OUT_OFFSET_W-1:0] o_end_offset,
    output logic        o_final_interval,
    output logic        o_wrapped
);
    import dpb_pkg::*;

    logic      rec_push;
    t_plan_rec rec;
    logic      q_full, q_nonempty, q_pop;
    t_plan_rec q_head;
    t_interval out_iv;

    // Classify each entry, advance offsets and merge with the held interval.
    dpb_front #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (push),
        .i_q_full        (q_full),
        .i_action        (i_action),
        .i_entry_size    (i_entry_size),
        .i_end_of_script (i_end_of_script),
        .o_rec_push      (rec_push),
        .o_rec           (rec)
    );

    // Decouple the entry side from the plan side.
    dpb_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (rec_push),
        .i_data     (rec),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    // Drain records one interval per transaction.
    dpb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_iv         (out_iv)
    );

    assign full             = q_full;
    assign o_origin_sel     = out_iv.origin;
    assign o_start_offset   = out_iv.start_off;
    assign o_end_offset     = out_iv.end_off;
    assign o_final_interval = out_iv.fin;
    assign o_wrapped        = out_iv.wrapped;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for delta_plan_builder_top: directed table, then random scripts.
module tb;
    import dpb_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int OFS_W          = OFFSET_WIDTH_DEF;
    localparam int LIMIT_CYCLES   = 10_000_000;
    localparam int RANDOM_ENTRIES = 1850;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic [31:0] SIZE_MAX   = 32'hFFFF_FFFF;

    // Plan-side stall patterns, taken in turn by the plan reader, one per window.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_SKIP_FOURTH,
        RX_RANDOM,
        RX_HOLD
    } t_rx_mode;

    // One row of the directed table; typed rows carry their intervals inline.
    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] size;
        logic        eos;
        logic        typed;
        logic [1:0]  n;
        t_interval   iv0;
        t_interval   iv1;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_action;
    logic [31:0] i_entry_size;
    logic        i_end_of_script;
    logic        empty;
    logic        pop;
    logic        o_origin_sel;
    logic [OUT_OFFSET_W-1:0] o_start_offset;
    logic [OUT_OFFSET_W-1:0] o_end_offset;
    logic        o_final_interval;
    logic        o_wrapped;

    delta_plan_builder_top #(
        .OFFSET_WIDTH(OFS_W)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_entry_size    (i_entry_size),
        .i_end_of_script (i_end_of_script),
        .empty           (empty),
        .pop             (pop),
        .o_origin_sel    (o_origin_sel),
        .o_start_offset  (o_start_offset),
        .o_end_offset    (o_end_offset),
        .o_final_interval(o_final_interval),
        .o_wrapped       (o_wrapped)
    );

    // Plan predictor state: running offsets, the interval being coalesced, sticky wrap.
    logic [OFS_W-1:0] src_ofs;
    logic [OFS_W-1:0] dst_ofs;
    logic             held_ok;
    logic             held_org;
    logic [OFS_W-1:0] held_start;
    logic [OFS_W-1:0] held_end;
    logic             wrap_seen;

    // Intervals predicted but not yet popped, oldest first.
    t_interval pending_intervals[$];
    t_dir_row  dir_rows[$];

    int fail_cnt          = 0;
    int entries_sent      = 0;
    int intervals_checked = 0;
    int double_entries    = 0;
    int burst_left        = 0;

    always begin
        i_clk = 1'b0;
        #(CLK_HALF);
        i_clk = 1'b1;
        #(CLK_HALF);
    end

    function automatic t_interval mk_iv(input logic org, input logic [OUT_OFFSET_W-1:0] s,
                                        input logic [OUT_OFFSET_W-1:0] e, input logic fin,
                                        input logic wr);
        t_interval iv;
        iv.origin    = org;
        iv.start_off = s;
        iv.end_off   = e;
        iv.fin       = fin;
        iv.wrapped   = wr;
        return iv;
    endfunction

    function automatic void clear_plan_state();
        src_ofs    = '0;
        dst_ofs    = '0;
        held_ok    = 1'b0;
        held_org   = ORIGIN_SRC;
        held_start = '0;
        held_end   = '0;
        wrap_seen  = 1'b0;
    endfunction

    // Advance an offset modulo 2^OFS_W; the carry out marks a wrap.
    function automatic logic [OFS_W-1:0] bump(input logic [OFS_W-1:0] pos,
                                              input logic [31:0] amt);
        logic [OFS_W:0] sum;
        sum = (OFS_W+1)'(pos) + (OFS_W+1)'(amt);
        if (sum[OFS_W])
            wrap_seen = 1'b1;
        return sum[OFS_W-1:0];
    endfunction

    // Apply one diff entry to the predictor; return how many intervals it emits.
    function automatic int plan_entry(input logic [1:0] act, input logic [31:0] sz,
                                      input logic eos, output t_interval first,
                                      output t_interval second);
        logic             have_new;
        logic             new_org;
        logic [OFS_W-1:0] new_start;
        logic [OFS_W-1:0] new_end;
        int               n;
        have_new  = 1'b0;
        new_org   = ORIGIN_SRC;
        new_start = '0;
        new_end   = '0;
        n         = 0;
        first     = '0;
        second    = '0;
        case (act)
            ACT_DROP: begin
                src_ofs = bump(src_ofs, sz);
            end
            ACT_KEEP: begin
                have_new  = 1'b1;
                new_org   = ORIGIN_SRC;
                new_start = src_ofs;
                src_ofs   = bump(src_ofs, sz);
                dst_ofs   = bump(dst_ofs, sz);
                new_end   = src_ofs;
            end
            ACT_INSERT: begin
                have_new  = 1'b1;
                new_org   = ORIGIN_DST;
                new_start = dst_ofs;
                dst_ofs   = bump(dst_ofs, sz);
                new_end   = dst_ofs;
            end
            default: ;
        endcase
        if (have_new) begin
            // Extend the held interval when origin matches and the bounds touch.
            if (held_ok && held_org == new_org && held_end == new_start) begin
                held_end = new_end;
            end else begin
                if (held_ok) begin
                    first = mk_iv(held_org, held_start, held_end, 1'b0, wrap_seen);
                    n = 1;
                end
                held_ok    = 1'b1;
                held_org   = new_org;
                held_start = new_start;
                held_end   = new_end;
            end
        end
        if (eos) begin
            if (held_ok) begin
                if (n == 0)
                    first = mk_iv(held_org, held_start, held_end, 1'b1, wrap_seen);
                else
                    second = mk_iv(held_org, held_start, held_end, 1'b1, wrap_seen);
                n++;
            end
            clear_plan_state();
        end
        return n;
    endfunction

    function automatic void add_row(input logic [1:0] act, input logic [31:0] sz,
                                    input logic eos, input logic typed, input int n,
                                    input t_interval a, input t_interval b);
        t_dir_row r;
        r.act   = act;
        r.size  = sz;
        r.eos   = eos;
        r.typed = typed;
        r.n     = 2'(n);
        r.iv0   = a;
        r.iv1   = b;
        dir_rows.push_back(r);
    endfunction

    // Offer one entry in bursts with random gaps, hold it until taken, then
    // queue the intervals it should produce (typed ones override the prediction).
    task automatic offer_entry(input logic [1:0] act, input logic [31:0] sz, input logic eos,
                               input logic typed, input int n_typed,
                               input t_interval t0, input t_interval t1);
        int        gap;
        int        n;
        t_interval p0;
        t_interval p1;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(8, 20);
            else
                gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        push            <= 1'b1;
        i_action        <= act;
        i_entry_size    <= sz;
        i_end_of_script <= eos;
        // Hold the transaction until an edge sees full low.
        do
            @(posedge i_clk);
        while (full);
        entries_sent++;
        n = plan_entry(act, sz, eos, p0, p1);
        if (typed) begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            pending_intervals.push_back(p0);
        if (n > 1) begin
            pending_intervals.push_back(p1);
            double_entries++;
        end
    endtask

    // Compare every popped interval with the oldest prediction.
    always @(posedge i_clk) begin : check_plan
        t_interval want;
        if (i_rst_n && pop && !empty) begin
            if (pending_intervals.size() == 0) begin
                $error("unexpected interval: origin_sel %0d start %0h end %0h",
                       o_origin_sel, o_start_offset, o_end_offset);
                fail_cnt++;
            end else begin
                want = pending_intervals.pop_front();
                intervals_checked++;
                if (o_origin_sel !== want.origin) begin
                    $error("origin_sel: expected %0d, got %0d", want.origin, o_origin_sel);
                    fail_cnt++;
                end
                if (o_start_offset !== want.start_off) begin
                    $error("start_offset: expected %0h, got %0h",
                           want.start_off, o_start_offset);
                    fail_cnt++;
                end
                if (o_end_offset !== want.end_off) begin
                    $error("end_offset: expected %0h, got %0h", want.end_off, o_end_offset);
                    fail_cnt++;
                end
                if (o_final_interval !== want.fin) begin
                    $error("final_interval: expected %0d, got %0d",
                           want.fin, o_final_interval);
                    fail_cnt++;
                end
                if (o_wrapped !== want.wrapped) begin
                    $error("wrapped: expected %0d, got %0d", want.wrapped, o_wrapped);
                    fail_cnt++;
                end
            end
        end
    end

    // Plan side: rotate stall patterns on a cycle count of its own. The hold
    // window keeps pop low at its start so the queue fills and full rises.
    initial begin : plan_reader
        int unsigned rx_cycle;
        t_rx_mode    mode;
        rx_cycle = 0;
        pop      = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            mode = t_rx_mode'((rx_cycle / 250) % 4);
            case (mode)
                RX_STREAM:      pop <= 1'b1;
                RX_SKIP_FOURTH: pop <= (rx_cycle % 4) != 3;
                RX_RANDOM:      pop <= ($urandom_range(0, 3) != 0);
                default:        pop <= (rx_cycle % 250) >= 150;
            endcase
        end
    end

    // Watchdog: end the run as failed once the time limit is reached.
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int          dir_count;
        int          rand_entries;
        int          scripts;
        int          script_len;
        int          pick;
        logic [1:0]  act;
        logic [31:0] sz;

        push            = 1'b0;
        i_action        = ACT_DROP;
        i_entry_size    = '0;
        i_end_of_script = 1'b0;
        i_rst_n         = 1'b0;
        rand_entries    = 0;
        scripts         = 0;
        clear_plan_state();

        // Directed table. Typed rows start from the reset state and are simple
        // enough to read off by hand; the rest go through the predictor.
        // Keep, keep merge into one source interval.
        add_row(ACT_KEEP,   32'd10,  1'b0, 1'b1, 0, '0, '0);
        add_row(ACT_KEEP,   32'd5,   1'b0, 1'b1, 0, '0, '0);
        // Insert changes origin: emit the source interval.
        add_row(ACT_INSERT, 32'd7,   1'b0, 1'b1, 1,
                mk_iv(ORIGIN_SRC, 48'd0, 48'd15, 1'b0, 1'b0), '0);
        // Empty insert still merges into the held destination interval.
        add_row(ACT_INSERT, 32'd0,   1'b0, 1'b1, 0, '0, '0);
        add_row(ACT_DROP,   32'd100, 1'b0, 1'b1, 0, '0, '0);
        // Last entry with a new interval: held one first, then the new one as final.
        add_row(ACT_KEEP,   32'd3,   1'b1, 1'b1, 2,
                mk_iv(ORIGIN_DST, 48'd15, 48'd22, 1'b0, 1'b0),
                mk_iv(ORIGIN_SRC, 48'd115, 48'd118, 1'b1, 1'b0));
        // Script of drops only emits nothing.
        add_row(ACT_DROP,   32'd5,   1'b1, 1'b1, 0, '0, '0);
        // Unused action code moves nothing, but end of script is honored.
        add_row(ACT_UNUSED, SIZE_MAX, 1'b0, 1'b1, 0, '0, '0);
        add_row(ACT_UNUSED, 32'd0,   1'b1, 1'b1, 0, '0, '0);
        // Single empty keep as a whole script.
        add_row(ACT_KEEP,   32'd0,   1'b1, 1'b1, 1,
                mk_iv(ORIGIN_SRC, 48'd0, 48'd0, 1'b1, 1'b0), '0);
        // Maximum sizes, a drop that breaks contiguity, flush by an unused code.
        add_row(ACT_INSERT, SIZE_MAX, 1'b0, 1'b0, 0, '0, '0);
        add_row(ACT_KEEP,   SIZE_MAX, 1'b0, 1'b0, 0, '0, '0);
        add_row(ACT_KEEP,   SIZE_MAX, 1'b0, 1'b0, 0, '0, '0);
        add_row(ACT_DROP,   32'd1,   1'b0, 1'b0, 0, '0, '0);
        add_row(ACT_KEEP,   32'd1,   1'b0, 1'b0, 0, '0, '0);
        add_row(ACT_UNUSED, 32'd2,   1'b1, 1'b0, 0, '0, '0);
        add_row(ACT_INSERT, 32'd4,   1'b0, 1'b0, 0, '0, '0);
        add_row(ACT_INSERT, 32'd4,   1'b1, 1'b0, 0, '0, '0);
        // Alternating size bit patterns.
        add_row(ACT_KEEP,   32'hAAAA_AAAA, 1'b0, 1'b0, 0, '0, '0);
        add_row(ACT_INSERT, 32'h5555_5555, 1'b1, 1'b0, 0, '0, '0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer_entry(dir_rows[i].act, dir_rows[i].size, dir_rows[i].eos,
                        dir_rows[i].typed, dir_rows[i].n, dir_rows[i].iv0, dir_rows[i].iv1);
        dir_count = entries_sent;

        // Random scripts: mostly keeps and inserts so intervals merge and
        // split often, with drops and unused codes mixed in.
        while (rand_entries < RANDOM_ENTRIES) begin
            script_len = $urandom_range(1, 10);
            scripts++;
            for (int k = 0; k < script_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    act = ACT_DROP;
                else if (pick < 60)
                    act = ACT_KEEP;
                else if (pick < 95)
                    act = ACT_INSERT;
                else
                    act = ACT_UNUSED;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: sz = $urandom_range(0, 16);
                    4, 5, 6:    sz = $urandom_range(0, 4095);
                    7, 8:       sz = $urandom;
                    default:    sz = $urandom_range(0, 1) ? SIZE_MAX : 32'd0;
                endcase
                offer_entry(act, sz, k == script_len - 1, 1'b0, 0, '0, '0);
                rand_entries++;
            end
        end

        @(negedge i_clk);
        push <= 1'b0;

        // Drain the plan side, then watch a little longer for strays.
        while (pending_intervals.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d diff entries: %0d directed, %0d random in %0d scripts.",
                 entries_sent, dir_count, rand_entries, scripts);
        $display("Checked %0d plan intervals, %0d entries emitting two; %0d mismatches.",
                 intervals_checked, double_entries, fail_cnt);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
design/dpb_pkg.sv
design/dpb_front.sv
design/dpb_queue.sv
design/dpb_back.sv
design/delta_plan_builder_top.sv
test/tb.sv
